[hw/rtl/dlle_pkg.sv]
// ----------------------------------------------------------------------------
// dlle_pkg
// Types and constants shared by the doubly linked list engine.
// ----------------------------------------------------------------------------
package dlle_pkg;

	localparam int unsigned POOL_DEPTH_DEF = 16;

	typedef enum logic [2:0] {
		CMD_INS_HEAD  = 3'd0,
		CMD_INS_TAIL  = 3'd1,
		CMD_INS_BEF   = 3'd2,
		CMD_INS_AFT   = 3'd3,
		CMD_DEL_HEAD  = 3'd4,
		CMD_DEL_TAIL  = 3'd5,
		CMD_DEL_KEY   = 3'd6,
		CMD_DUMP      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] search_key;
		logic signed [31:0] new_value;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] item_value;
		logic [4:0]         list_length;
		logic               last_of_run;
	} out_beat_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic        shift_ins;  // open a slot at ins_pos and write value there
		logic        shift_del;  // close the slot at del_pos
		logic [31:0] value;
		logic [31:0] key;
	} cell_ctl_t;

endpackage

[hw/rtl/dlle_cell.sv]
// ----------------------------------------------------------------------------
// dlle_cell
// One list position: holds a value, compares it with the key and shifts
// with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module dlle_cell
	import dlle_pkg::*;
(
	input  logic        clk,
	input  cell_ctl_t   ctl,
	input  logic        at_ins,     // this cell is the insert slot
	input  logic        past_ins,   // this cell lies after the insert slot
	input  logic        from_del,   // this cell lies at or after the delete slot
	input  logic [31:0] left_value,
	input  logic [31:0] right_value,
	output logic [31:0] value,
	output logic        match
);

	logic [31:0] value_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_ins && at_ins) begin
			value_q <= ctl.value;
		end else if (ctl.shift_ins && past_ins) begin
			value_q <= left_value;
		end else if (ctl.shift_del && from_del) begin
			value_q <= right_value;
		end
	end

	assign value = value_q;
	assign match = (value_q == ctl.key);

endmodule

[hw/rtl/doubly_linked_list_engine_core.sv]
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_core
// Ordered list of signed 32-bit values with head, tail and keyed inserts and
// deletes plus an ordered dump.
// ----------------------------------------------------------------------------
// The list is kept as a row of POOL_DEPTH cells in head-to-tail order; an
// insert or delete shifts the cells past the touched position by one, and
// a key search compares all cells at once. A command that gives one result
// is accepted in S_IDLE, then decided, updated and its result registered in
// S_EXEC; a dump then registers one value per cycle from the head in S_DUMP
// while the output is not stalled. Output is a registered beat: a new
// command can be taken while the previous command's last beat still waits
// in the output register, and the engine waits in S_EXEC or S_DUMP while
// the output register holds a stalled beat.
module doubly_linked_list_engine_core
	import dlle_pkg::*;
#(
	parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	localparam int unsigned IW = $clog2(POOL_DEPTH);
	localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DUMP = 3'b100
	} state_t;

	state_t           state_q;
	in_beat_t         cmd_q;
	logic [CW-1:0]    count_q;
	logic [IW-1:0]    dptr_q;
	logic             ovalid_q;
	out_beat_t        obeat_q;

	cell_ctl_t        ctl;
	logic [31:0]      vals [POOL_DEPTH];
	logic [POOL_DEPTH-1:0] match_v, live_v;
	logic [IW-1:0]    hit_idx;
	logic             hit_any;
	logic [IW-1:0]    ins_pos, del_pos;
	logic             out_free;

	assign out_free = !ovalid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// first live match, lowest position wins
	always_comb begin
		hit_idx = '0;
		hit_any = 1'b0;
		for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
			if (match_v[i] && live_v[i]) begin
				hit_idx = IW'(i);
				hit_any = 1'b1;
			end
		end
	end

	always_comb begin
		unique case (cmd_t'(cmd_q.command))
			CMD_INS_HEAD: ins_pos = '0;
			CMD_INS_TAIL: ins_pos = count_q[IW-1:0];
			CMD_INS_BEF:  ins_pos = hit_idx;
			default:      ins_pos = hit_idx + IW'(1);
		endcase
		unique case (cmd_t'(cmd_q.command))
			CMD_DEL_HEAD: del_pos = '0;
			CMD_DEL_TAIL: del_pos = IW'(count_q - CW'(1));
			default:      del_pos = hit_idx;
		endcase
	end

	logic is_ins, is_del, empty, full, need_key, key_ok, do_op;
	assign is_ins   = !cmd_q.command[2];
	assign is_del   = cmd_q.command[2] && (cmd_t'(cmd_q.command) != CMD_DUMP);
	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(POOL_DEPTH));
	assign need_key = (cmd_t'(cmd_q.command) == CMD_INS_BEF)
		|| (cmd_t'(cmd_q.command) == CMD_INS_AFT)
		|| (cmd_t'(cmd_q.command) == CMD_DEL_KEY);
	assign key_ok   = !need_key || hit_any;
	assign do_op    = (state_q == S_EXEC) && out_free && key_ok
		&& (is_ins ? !full : (is_del && !empty));

	assign ctl.shift_ins = do_op && is_ins;
	assign ctl.shift_del = do_op && is_del;
	assign ctl.value     = cmd_q.new_value;
	assign ctl.key       = cmd_q.search_key;

	// single-result beat; deletes and dump see an empty list before the search
	status_t     exec_status;
	logic [31:0] exec_value;
	logic [4:0]  exec_len;

	always_comb begin
		exec_status = ST_OK;
		exec_value  = '0;
		exec_len    = 5'(count_q);
		if (!is_ins && empty) begin
			exec_status = ST_EMPTY;
		end else if (!key_ok) begin
			exec_status = ST_NOTFOUND;
		end else if (is_ins && full) begin
			exec_status = ST_FULL;
		end else if (is_ins) begin
			exec_len = 5'(count_q + CW'(1));
		end else if (is_del) begin
			exec_value = vals[del_pos];
			exec_len   = 5'(count_q - CW'(1));
		end
	end

	for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
		logic [31:0] lv, rv;
		if (g == 0) begin : g_l
			assign lv = '0;
		end else begin : g_l
			assign lv = vals[g-1];
		end
		if (g == POOL_DEPTH - 1) begin : g_r
			assign rv = '0;
		end else begin : g_r
			assign rv = vals[g+1];
		end
		assign live_v[g] = (CW'(g) < count_q);
		dlle_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.at_ins      (ins_pos == IW'(g)),
			.past_ins    (IW'(g) > ins_pos),
			.from_del    (IW'(g) >= del_pos),
			.left_value  (lv),
			.right_value (rv),
			.value       (vals[g]),
			.match       (match_v[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			dptr_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (out_free) begin
						ovalid_q <= 1'b0;
					end
					if (in_valid && !in_stall) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						dptr_q <= '0;
						if (ctl.shift_ins) begin
							count_q <= count_q + CW'(1);
						end else if (ctl.shift_del) begin
							count_q <= count_q - CW'(1);
						end
						if (cmd_t'(cmd_q.command) == CMD_DUMP && !empty) begin
							state_q  <= S_DUMP;
							ovalid_q <= 1'b0;
						end else begin
							state_q  <= S_IDLE;
							ovalid_q <= 1'b1;
						end
					end
				end
				S_DUMP: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						dptr_q   <= dptr_q + IW'(1);
						if (CW'(dptr_q) + CW'(1) == count_q) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !in_stall) begin
			cmd_q <= in_data;
		end
		if (state_q == S_EXEC && out_free) begin
			obeat_q.status      <= exec_status;
			obeat_q.item_value  <= exec_value;
			obeat_q.list_length <= exec_len;
			obeat_q.last_of_run <= 1'b1;
		end else if (state_q == S_DUMP && out_free) begin
			obeat_q.status      <= ST_OK;
			obeat_q.item_value  <= vals[dptr_q];
			obeat_q.list_length <= 5'(count_q);
			obeat_q.last_of_run <= (CW'(dptr_q) + CW'(1) == count_q);
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = obeat_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(POOL_DEPTH))
		else $error("node count beyond pool");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.shift_ins && ctl.shift_del))
		else $error("insert and delete together");
	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && out_free) |=> ovalid_q || state_q == S_DUMP)
		else $error("command gave no beat");
	a_dump_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> CW'(dptr_q) < count_q)
		else $error("dump past tail");

endmodule

[verif/tb_doubly_linked_list_engine_core.sv]
// ----------------------------------------------------------------------------
// tb_doubly_linked_list_engine_core
// Drives list commands through the valid/stall channel and compares every
// output beat against an ordered list model kept in the testbench.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_engine_core
	import dlle_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = POOL_DEPTH_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int N_RANDOM = 340;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_beat_t out_data;

	doubly_linked_list_engine_core #(.POOL_DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #10 clk = ~clk;

	// list contents, head first
	logic signed [31:0] list_vals[$];
	out_beat_t expected_beats[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit stim_done = 1'b0;

	function automatic out_beat_t mk_beat(status_t st, logic signed [31:0] v, bit last);
		out_beat_t b;
		b.status = st;
		b.item_value = v;
		b.list_length = 5'(list_vals.size());
		b.last_of_run = last;
		return b;
	endfunction

	function automatic int find_first(logic signed [31:0] key);
		foreach (list_vals[i])
			if (list_vals[i] == key)
				return i;
		return -1;
	endfunction

	task automatic apply_command(in_beat_t c);
		int pos;
		logic signed [31:0] v;
		case (cmd_t'(c.command))
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_BEF, CMD_INS_AFT: begin
				pos = 0;
				if (c.command == CMD_INS_BEF || c.command == CMD_INS_AFT) begin
					pos = find_first(c.search_key);
					if (pos < 0) begin
						expected_beats.push_back(mk_beat(ST_NOTFOUND, 0, 1));
						return;
					end
				end
				if (list_vals.size() >= DEPTH) begin
					expected_beats.push_back(mk_beat(ST_FULL, 0, 1));
					return;
				end
				case (cmd_t'(c.command))
					CMD_INS_HEAD: list_vals.push_front(c.new_value);
					CMD_INS_TAIL: list_vals.push_back(c.new_value);
					CMD_INS_BEF:  list_vals.insert(pos, c.new_value);
					default:      list_vals.insert(pos + 1, c.new_value);
				endcase
				expected_beats.push_back(mk_beat(ST_OK, 0, 1));
			end
			CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_KEY: begin
				if (list_vals.size() == 0) begin
					expected_beats.push_back(mk_beat(ST_EMPTY, 0, 1));
					return;
				end
				if (c.command == CMD_DEL_HEAD)
					pos = 0;
				else if (c.command == CMD_DEL_TAIL)
					pos = list_vals.size() - 1;
				else
					pos = find_first(c.search_key);
				if (pos < 0) begin
					expected_beats.push_back(mk_beat(ST_NOTFOUND, 0, 1));
					return;
				end
				v = list_vals[pos];
				list_vals.delete(pos);
				expected_beats.push_back(mk_beat(ST_OK, v, 1));
			end
			default: begin
				if (list_vals.size() == 0)
					expected_beats.push_back(mk_beat(ST_EMPTY, 0, 1));
				else
					foreach (list_vals[i])
						expected_beats.push_back(mk_beat(ST_OK, list_vals[i],
							i == list_vals.size() - 1));
			end
		endcase
	endtask

	// output checker
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && in_valid && !in_stall)
			idle_cycles <= 0;
		else if (arst_n && out_valid && !out_stall)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: %p", out_data);
			end else begin
				e = expected_beats.pop_front();
				if (out_data !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat mismatch: exp %p got %p", e, out_data);
				end
			end
		end
	end

	// receiver stalls
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			out_stall <= (w != 0);
			repeat (w) @(negedge clk);
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send(in_beat_t c, bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 9) : 0;
		if (w != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (w - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		apply_command(c);
	endtask

	function automatic logic signed [31:0] pick_value();
		if (list_vals.size() != 0 && $urandom_range(0, 3) != 0)
			return list_vals[$urandom_range(0, list_vals.size() - 1)];
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 7);
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	// directed rows; status typed in where it is plain, else predictor only
	typedef struct {
		cmd_t               cmd;
		logic signed [31:0] key;
		logic signed [31:0] val;
		bit                 has_exp;
		status_t            exp_st;
	} row_t;

	row_t rows[] = '{
		'{CMD_DUMP,     0, 0, 1'b1, ST_EMPTY},
		'{CMD_DEL_HEAD, 0, 0, 1'b1, ST_EMPTY},
		'{CMD_DEL_TAIL, 0, 0, 1'b1, ST_EMPTY},
		'{CMD_DEL_KEY,  5, 0, 1'b1, ST_EMPTY},
		'{CMD_INS_BEF,  5, 1, 1'b1, ST_NOTFOUND},
		'{CMD_INS_AFT,  5, 1, 1'b1, ST_NOTFOUND},
		'{CMD_INS_HEAD, 0, 32'sh7fffffff, 1'b1, ST_OK},
		'{CMD_INS_TAIL, 0, 32'sh80000000, 1'b1, ST_OK},
		'{CMD_INS_BEF,  32'sh7fffffff, -1, 1'b0, ST_OK},
		'{CMD_INS_AFT,  32'sh80000000, 0, 1'b0, ST_OK},
		'{CMD_INS_AFT,  -1, 32'sh55555555, 1'b0, ST_OK},
		'{CMD_INS_BEF,  0, 32'shaaaaaaaa, 1'b0, ST_OK},
		'{CMD_DUMP,     0, 0, 1'b0, ST_OK},
		'{CMD_DEL_KEY,  123, 0, 1'b1, ST_NOTFOUND},
		'{CMD_INS_BEF,  123, 4, 1'b1, ST_NOTFOUND},
		'{CMD_DEL_KEY,  32'sh55555555, 0, 1'b0, ST_OK},
		'{CMD_DEL_HEAD, 0, 0, 1'b0, ST_OK},
		'{CMD_DEL_TAIL, 0, 0, 1'b0, ST_OK},
		'{CMD_DUMP,     0, 0, 1'b0, ST_OK}
	};

	initial begin
		in_beat_t c;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			c.command = rows[i].cmd;
			c.search_key = rows[i].key;
			c.new_value = rows[i].val;
			send(c, 1'b1);
			if (rows[i].has_exp && expected_beats.size() != 0
					&& expected_beats[$].status != rows[i].exp_st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: exp status %0d got %0d", i,
						rows[i].exp_st, expected_beats[$].status);
			end
		end

		// fill to full, refuse, dump the whole pool
		for (int i = 0; i < DEPTH + 2; i++) begin
			c.command = ($urandom_range(0, 1) != 0) ? CMD_INS_HEAD : CMD_INS_TAIL;
			c.search_key = 0;
			c.new_value = $urandom;
			send(c, 1'b0);
		end
		c.command = CMD_INS_AFT;
		c.search_key = list_vals[3];
		send(c, 1'b0);
		c.command = CMD_DUMP;
		send(c, 1'b0);

		// let the engine drain completely once
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 35)
				c.command = cmd_t'($urandom_range(0, 3));
			else if (r < 70)
				c.command = cmd_t'($urandom_range(4, 6));
			else if (r < 80)
				c.command = CMD_DUMP;
			else
				c.command = cmd_t'($urandom_range(0, 7));
			// bias inserts so the list fills and empties repeatedly
			if ((i / 60) % 2 == 0 && c.command >= CMD_DEL_HEAD && c.command != CMD_DUMP
					&& $urandom_range(0, 1) != 0)
				c.command = CMD_INS_TAIL;
			c.search_key = pick_value();
			c.new_value = ($urandom_range(0, 2) == 0) ? pick_value() : $urandom;
			send(c, ((i / 40) % 3) != 2);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// end of run and watchdog
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_doubly_linked_list_engine_core: done, errors");
				$finish;
			end
			if (stim_done && expected_beats.size() == 0)
				break;
		end
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_beats.size() == 0)
			$display("tb_doubly_linked_list_engine_core: done, clean");
		else
			$display("tb_doubly_linked_list_engine_core: done, errors");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/dlle_pkg.sv
hw/rtl/dlle_cell.sv
hw/rtl/doubly_linked_list_engine_core.sv
verif/tb_doubly_linked_list_engine_core.sv
